### src/wbs_pkg.sv
// Shared constants and types of the word break segmenter.
package wbs_pkg;

    localparam int DICT_WORDS_DEF   = 16;
    localparam int MAX_WORD_LEN_DEF = 16;

    localparam logic [1:0] KIND_DICT  = 2'd0;
    localparam logic [1:0] KIND_TEXT  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic load_shift;  // shift a dictionary character into this cell
        logic len_write;   // the word in this cell is complete, store its length
        logic capture;     // register the compare result for a text character
        logic word_valid;  // this cell holds a word of the current dictionary
    } wbs_cell_ctrl_t;

endpackage

### src/wbs_cell.sv
// One dictionary cell: holds one word, newest character first, and compares it to the text.
module wbs_cell
    import wbs_pkg::*;
#(
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  wbs_cell_ctrl_t            ctrl,
    input  logic [7:0]                char_code,
    input  logic [$clog2(MAX_WORD_LEN+1)-1:0] len_data,
    input  logic [MAX_WORD_LEN*8-1:0] hist,
    input  logic [MAX_WORD_LEN-1:0]   seg,
    input  logic                      hit_in,
    output logic                      hit_out
);

    localparam int LW = $clog2(MAX_WORD_LEN + 1);

    logic [MAX_WORD_LEN*8-1:0] chars_reg;
    logic [LW-1:0]             len_reg;
    logic                      match_reg;
    logic                      match_next;
    logic                      eq_all;
    logic                      seg_ok;

    // Characters enter at slot 0, so once a word is complete slot i holds the
    // character i places before its end and lines up with text history slot i.
    always_comb
    begin
        eq_all = 1'b1;
        seg_ok = 1'b0;
        for (int i = 0; i < MAX_WORD_LEN; i++)
        begin
            if ((LW'(i) < len_reg) && (chars_reg[i*8 +: 8] != hist[i*8 +: 8]))
            begin
                eq_all = 1'b0;
            end
            if (len_reg == LW'(i + 1))
            begin
                seg_ok = seg[i];
            end
        end
        match_next = ctrl.word_valid && (len_reg != '0) && seg_ok && eq_all;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_shift)
        begin
            chars_reg <= (MAX_WORD_LEN*8)'({chars_reg, char_code});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.len_write)
            begin
                len_reg <= len_data;
            end
            if (ctrl.capture)
            begin
                match_reg <= match_next;
            end
        end
    end

    assign hit_out = hit_in | match_reg;

endmodule

### src/word_break_segmenter_core.sv
// Top level of the word break segmenter: control, shared history and the row of word cells.
//
// Dictionary, clear and unused-kind transactions are handled as they are taken. A
// text transaction runs in two steps: first every word cell compares its word
// with the text history in parallel and registers the result, then the hits
// of all DICT_WORDS cells are combined along the cell row and the prefix
// history is shifted. The next text character needs that updated prefix
// history, so no new transaction is taken until the combine step is done. The
// result sits in an output register; a dictionary, clear or unused-kind
// transaction is taken while it waits, a text transaction once the output
// register is free or being emptied.
module word_break_segmenter_core
    import wbs_pkg::*;
#(
    parameter int DICT_WORDS   = DICT_WORDS_DEF,
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [7:0] char_code,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       prefix_breakable,
    output logic       string_done,
    output logic       dict_overflow
);

    localparam int CW = $clog2(DICT_WORDS + 1);
    localparam int PW = $clog2(MAX_WORD_LEN + 2);
    localparam int LW = $clog2(MAX_WORD_LEN + 1);

    typedef enum logic {
        S_IDLE,
        S_REDUCE
    } state_t;

    state_t                    state_reg;
    logic [CW-1:0]             word_count_reg;
    logic [PW-1:0]             load_pos_reg;
    logic                      overflow_reg;
    logic [MAX_WORD_LEN*8-1:0] hist_reg;
    logic [MAX_WORD_LEN*8-1:0] hist_next;
    logic [MAX_WORD_LEN-1:0]   seg_reg;
    logic                      last_reg;
    logic                      out_valid_reg;
    logic                      prefix_breakable_reg;
    logic                      string_done_reg;
    logic                      dict_overflow_reg;

    logic                      accept;
    logic                      dict_accept;
    logic                      text_accept;
    logic                      clear_accept;
    logic [PW-1:0]             load_pos_inc;
    logic                      store_char;
    logic                      word_fits;
    logic [LW-1:0]             len_data;
    logic [DICT_WORDS:0]       hit_chain;
    logic                      hit;

    assign in_ready = (state_reg == S_IDLE) &&
                      ((kind != KIND_TEXT) || !out_valid_reg || out_ready);
    assign accept       = in_valid && in_ready;
    assign dict_accept  = accept && (kind == KIND_DICT);
    assign text_accept  = accept && (kind == KIND_TEXT);
    assign clear_accept = accept && (kind == KIND_CLEAR);

    assign load_pos_inc = (load_pos_reg <= PW'(MAX_WORD_LEN)) ? load_pos_reg + 1'b1
                                                              : load_pos_reg;
    assign store_char   = (word_count_reg < CW'(DICT_WORDS)) &&
                          (load_pos_reg < PW'(MAX_WORD_LEN));
    assign word_fits    = (word_count_reg < CW'(DICT_WORDS)) &&
                          (load_pos_inc <= PW'(MAX_WORD_LEN));
    assign len_data     = LW'(load_pos_inc);

    // The cells compare against the history that already holds this character.
    assign hist_next = (MAX_WORD_LEN*8)'({hist_reg, char_code});

    assign hit_chain[0] = 1'b0;
    assign hit          = hit_chain[DICT_WORDS];

    for (genvar w = 0; w < DICT_WORDS; w++)
    begin : g_cell
        wbs_cell_ctrl_t ctrl;
        logic           sel;

        assign sel             = (word_count_reg == CW'(w));
        assign ctrl.load_shift = dict_accept && sel && store_char;
        assign ctrl.len_write  = dict_accept && sel && last && word_fits;
        assign ctrl.capture    = text_accept;
        assign ctrl.word_valid = (word_count_reg > CW'(w));

        wbs_cell #(
            .MAX_WORD_LEN (MAX_WORD_LEN)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .char_code (char_code),
            .len_data  (len_data),
            .hist      (hist_next),
            .seg       (seg_reg),
            .hit_in    (hit_chain[w]),
            .hit_out   (hit_chain[w+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            word_count_reg       <= '0;
            load_pos_reg         <= '0;
            overflow_reg         <= 1'b0;
            hist_reg             <= '0;
            seg_reg              <= MAX_WORD_LEN'(1);
            last_reg             <= 1'b0;
            out_valid_reg        <= 1'b0;
            prefix_breakable_reg <= 1'b0;
            string_done_reg      <= 1'b0;
            dict_overflow_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (dict_accept)
                    begin
                        if (last)
                        begin
                            load_pos_reg <= '0;
                            if (word_fits)
                            begin
                                word_count_reg <= word_count_reg + 1'b1;
                            end
                            else
                            begin
                                overflow_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            load_pos_reg <= load_pos_inc;
                        end
                    end
                    if (clear_accept)
                    begin
                        word_count_reg <= '0;
                        load_pos_reg   <= '0;
                        overflow_reg   <= 1'b0;
                    end
                    if (text_accept)
                    begin
                        hist_reg  <= hist_next;
                        last_reg  <= last;
                        state_reg <= S_REDUCE;
                    end
                end
                S_REDUCE:
                begin
                    out_valid_reg        <= 1'b1;
                    prefix_breakable_reg <= hit;
                    string_done_reg      <= last_reg;
                    dict_overflow_reg    <= overflow_reg;
                    if (last_reg)
                    begin
                        // End of string: back to the empty prefix.
                        hist_reg <= '0;
                        seg_reg  <= MAX_WORD_LEN'(1);
                    end
                    else
                    begin
                        seg_reg <= MAX_WORD_LEN'({seg_reg, hit});
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign prefix_breakable = prefix_breakable_reg;
    assign string_done      = string_done_reg;
    assign dict_overflow    = dict_overflow_reg;

    a_text_goes_to_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (kind == KIND_TEXT)) |=> (state_reg == S_REDUCE))
        else $error("text transaction did not enter the combine cycle");

    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REDUCE) |-> (!out_valid_reg || out_ready))
        else $error("result would overwrite a pending output transaction");

    a_word_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        word_count_reg <= CW'(DICT_WORDS))
        else $error("word count exceeds dictionary capacity");

    a_load_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_pos_reg <= PW'(MAX_WORD_LEN + 1))
        else $error("load position beyond saturation");

    a_restart_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_REDUCE) && last_reg) |=> (seg_reg == MAX_WORD_LEN'(1)))
        else $error("prefix history not restarted at end of string");

endmodule

### test/tb_top.sv
// Self-checking testbench for the word break segmenter core with a scoreboard class.
module tb_top;
    import wbs_pkg::*;

    localparam int NW = DICT_WORDS_DEF;
    localparam int WL = MAX_WORD_LEN_DEF;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic breakable;
        logic done;
        logic overflow;
    } seg_result_t;

    class segment_scoreboard;
        byte unsigned word_chars[NW*WL];
        int unsigned  word_len[NW];
        int unsigned  word_count;
        int unsigned  load_pos;
        int unsigned  text_pos;
        byte unsigned text_hist[WL];
        bit           prefix_ok[WL+1];
        bit           overflow;
        seg_result_t  expected_q[$];
        int           errors;
        int           results_seen;
        int           hits_seen;
        int           strings_seen;
        int           overflow_seen;

        function new();
            foreach (word_chars[i]) word_chars[i] = 8'h00;
            foreach (word_len[i]) word_len[i] = 0;
            word_count    = 0;
            load_pos      = 0;
            overflow      = 1'b0;
            errors        = 0;
            results_seen  = 0;
            hits_seen     = 0;
            strings_seen  = 0;
            overflow_seen = 0;
            restart_text();
        endfunction

        function void restart_text();
            foreach (text_hist[i]) text_hist[i] = 8'h00;
            foreach (prefix_ok[i]) prefix_ok[i] = 1'b0;
            prefix_ok[0] = 1'b1;
            text_pos     = 0;
        endfunction

        // Updates the dictionary and text state for one accepted transaction.
        function void note_input(logic [1:0] k, logic [7:0] c, logic l);
            seg_result_t r;
            bit          hit;
            bit          same;
            int unsigned m;
            if (k == KIND_DICT)
            begin
                if (word_count < NW && load_pos < WL)
                    word_chars[word_count*WL + load_pos] = c;
                if (load_pos <= WL)
                    load_pos++;
                if (l)
                begin
                    // A word is kept only if there is room and it fits.
                    if (word_count < NW && load_pos <= WL)
                    begin
                        word_len[word_count] = load_pos;
                        word_count++;
                    end
                    else
                        overflow = 1'b1;
                    load_pos = 0;
                end
            end
            else if (k == KIND_CLEAR)
            begin
                word_count = 0;
                load_pos   = 0;
                overflow   = 1'b0;
            end
            else if (k == KIND_TEXT)
            begin
                for (int i = WL - 1; i > 0; i--)
                    text_hist[i] = text_hist[i-1];
                text_hist[0] = c;
                if (text_pos < WL)
                    text_pos++;
                hit = 1'b0;
                for (int w = 0; w < word_count && !hit; w++)
                begin
                    m = word_len[w];
                    if (m != 0 && m <= text_pos && prefix_ok[m-1])
                    begin
                        same = 1'b1;
                        for (int j = 0; j < m; j++)
                            if (word_chars[w*WL + j] != text_hist[m-1-j])
                                same = 1'b0;
                        hit = same;
                    end
                end
                for (int i = WL; i > 0; i--)
                    prefix_ok[i] = prefix_ok[i-1];
                prefix_ok[0] = hit;
                r.breakable  = hit;
                r.done       = l;
                r.overflow   = overflow;
                expected_q.push_back(r);
                if (l)
                    restart_text();
            end
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic b, logic d, logic o);
            seg_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with nothing pending (breakable=%0b done=%0b ovf=%0b)",
                                 b, d, o));
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            hits_seen     += want.breakable;
            strings_seen  += want.done;
            overflow_seen += want.overflow;
            if (b !== want.breakable)
                report($sformatf("prefix_breakable %0b, expected %0b", b, want.breakable));
            if (d !== want.done)
                report($sformatf("string_done %0b, expected %0b", d, want.done));
            if (o !== want.overflow)
                report($sformatf("dict_overflow %0b, expected %0b", o, want.overflow));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] kind;
    logic [7:0] char_code;
    logic       last;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       prefix_breakable;
    logic       string_done;
    logic       dict_overflow;

    segment_scoreboard sb;
    int           idle_pct;
    int           items_sent;
    int           stall_left = 0;
    byte unsigned alphabet[3];
    byte unsigned dict_text[20][20];
    int           dict_len[20];
    int           dict_n;

    word_break_segmenter_core DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .char_code        (char_code),
        .last             (last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .prefix_breakable (prefix_breakable),
        .string_done      (string_done),
        .dict_overflow    (dict_overflow)
    );

    always #6 clk = ~clk;

    // Receiver: stalls come in bursts of random length.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            stall_left <= $urandom_range(0, 4);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Handshakes are judged at the falling edge, where every signal is settled.
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready)
            sb.check_result(prefix_breakable, string_done, dict_overflow);
    end

    // Called at a rising edge; returns at the rising edge that took the transaction.
    task send_item(input logic [1:0] k, input logic [7:0] c, input logic l);
        // The closing stretch of the run always goes at full speed on both sides.
        if (items_sent >= 1150)
            idle_pct = 0;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        char_code <= c;
        last      <= l;
        do @(negedge clk); while (in_ready !== 1'b1);
        sb.note_input(k, c, l);
        if (k != KIND_UNUSED)
            items_sent++;
        @(posedge clk);
    endtask

    function int pick_len();
        int sel;
        sel = $urandom_range(0, 29);
        if (sel == 0)
            return WL;
        if (sel == 1)
            return $urandom_range(WL + 1, 20);
        if (sel < 6)
            return $urandom_range(4, 6);
        return $urandom_range(1, 3);
    endfunction

    task load_word(input int len, input int slot);
        byte unsigned c;
        for (int j = 0; j < len; j++)
        begin
            c = alphabet[$urandom_range(0, 2)];
            dict_text[slot][j] = c;
            send_item(KIND_DICT, c, j == len - 1);
        end
        dict_len[slot] = len;
    endtask

    // Text built mostly from known words so that the recurrence gets deep.
    task send_string(input int nwords);
        byte unsigned chars[$];
        int           w;
        for (int i = 0; i < nwords; i++)
        begin
            if (dict_n > 0)
            begin
                w = $urandom_range(0, dict_n - 1);
                for (int j = 0; j < dict_len[w]; j++)
                    chars.push_back(dict_text[w][j]);
            end
            if (dict_n == 0 || $urandom_range(0, 7) == 0)
                chars.push_back(8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < chars.size(); i++)
        begin
            if ($urandom_range(0, 59) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    send_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    dict_n = 0;
                end
                else if (dict_n < 20)
                begin
                    load_word(pick_len(), dict_n);
                    dict_n++;
                end
            end
            if ($urandom_range(0, 79) == 0)
                send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            send_item(KIND_TEXT, chars[i], i == chars.size() - 1);
        end
    endtask

    initial
    begin
        int n;
        sb = new();
        idle_pct   = 0;
        items_sent = 0;
        dict_n     = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        kind      <= KIND_DICT;
        char_code <= 8'h00;
        last      <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty dictionary, extreme bytes, overlapping words, ignored code,
        // a word one character too long, and a clear in the middle of a string.
        send_item(KIND_TEXT, 8'h00, 1'b1);
        send_item(KIND_DICT, 8'hFF, 1'b1);
        send_item(KIND_DICT, 8'h00, 1'b0);
        send_item(KIND_DICT, 8'hFF, 1'b1);
        send_item(KIND_TEXT, 8'h00, 1'b0);
        send_item(KIND_TEXT, 8'hFF, 1'b0);
        send_item(KIND_TEXT, 8'hFF, 1'b1);
        send_item(KIND_UNUSED, 8'hA5, 1'b1);
        for (int i = 0; i <= WL; i++)
            send_item(KIND_DICT, 8'h5A, i == WL);
        send_item(KIND_TEXT, 8'hFF, 1'b0);
        send_item(KIND_CLEAR, 8'h00, 1'b0);
        send_item(KIND_TEXT, 8'hFF, 1'b1);

        // Random rounds: fresh alphabet and dictionary, then several strings.
        while (items_sent < 1300)
        begin
            if (items_sent >= 1150)
                idle_pct = 0;
            else
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 8;
                    default: idle_pct = 25;
                endcase
            foreach (alphabet[i]) alphabet[i] = 8'($urandom_range(0, 255));
            send_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            // Now and then the dictionary is filled past its capacity.
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(NW - 1, NW + 2) : $urandom_range(1, 8);
            dict_n = n;
            for (int w = 0; w < n; w++)
                load_word(pick_len(), w);
            repeat ($urandom_range(3, 8)) send_string($urandom_range(1, 6));
        end

        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d transactions; checked %0d prefix results over %0d strings.",
                 items_sent, sb.results_seen, sb.strings_seen);
        $display("%0d prefixes were breakable and %0d results carried the overflow flag.",
                 sb.hits_seen, sb.overflow_seen);
        if (sb.errors == 0)
            $display("word_break_segmenter_core test passed");
        else
            $display("word_break_segmenter_core test failed");
        $finish;
    end

    initial
    begin
        #(12 * 400000);
        $display("Timeout: the segmenter stopped making progress.");
        $display("word_break_segmenter_core test failed");
        $finish;
    end

endmodule

### word_break_segmenter_core.f
src/wbs_pkg.sv
src/wbs_cell.sv
src/word_break_segmenter_core.sv
test/tb_top.sv
